/* design/lzwenc16_pkg.sv */
`timescale 1ns / 1ps

package lzwenc16_pkg;

    // Dictionary geometry and code format
    localparam int DICT_ENTRIES_DEF = 65536;
    localparam int FIRST_CODE       = 256;
    localparam int CODE_W           = 16;
    localparam int BYTE_W           = 8;
    localparam int CAP_W            = 24;
    localparam int ENTRY_W          = CODE_W + BYTE_W;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    // Input word: one source byte
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } in_word_t;

    // Output word: one emitted code
    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic              overflow;
        logic              end_of_run;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_first;
        logic search_start;
        logic load_hit;
        logic emit;
        logic emit_end;
        logic add_entry;
        logic restart;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic failed;
        logic prefix_valid;
        logic last;
        logic search_done;
        logic search_hit;
        logic slot_free;
        logic emit_ok;
    } ctrl_sts_t;

endpackage

/* design/lzw_encoder_16bit_codes_top.sv */
`timescale 1ns / 1ps

// Channel  Signals                          Word
// -------  -------------------------------  -----------------------------------
// in       in_valid / in_ready / in_word    byte_in, last_byte
// out      out_valid / out_ready / out_word code_out, overflow, end_of_run
// cfg      cfg_valid / cfg_ready / cfg_data output_capacity (24 bits)
//
// One byte in flight; a first byte goes through DECIDE and back to IDLE.
// Other bytes scan the dictionary one entry a cycle (single RAM read port)
// from entry 256 up to the next free code, stopping at the first hit;
// the last byte of a stream that has not overflowed adds a flush state.
// Emitting waits while the out word register is full and out_ready is low.
// No clearing pass after reset; only entries written this stream are read.

module lzw_encoder_16bit_codes_top #(
    parameter int DICT_ENTRIES = lzwenc16_pkg::DICT_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lzwenc16_pkg::in_word_t          in_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lzwenc16_pkg::out_word_t         out_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lzwenc16_pkg::CAP_W-1:0]  cfg_data
);

    import lzwenc16_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    lzwenc16_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzwenc16_dp #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // A word is only loaded into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.slot_free)
        else $error("word emitted over a pending output word");

    // One byte at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("byte accepted while previous byte still in work");

    // An overflow word always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.overflow |-> out_word.end_of_run)
        else $error("overflow word without end_of_run");

    // A hit is only reported when the scan ends
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.search_hit |-> sts.search_done)
        else $error("search hit outside a finished scan");

endmodule

/* design/lzwenc16_ram.sv */
`timescale 1ns / 1ps

module lzwenc16_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/lzwenc16_ctrl.sv */
`timescale 1ns / 1ps

module lzwenc16_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lzwenc16_pkg::ctrl_sts_t sts,
    output lzwenc16_pkg::ctrl_cmd_t cmd
);

    import lzwenc16_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencing of one byte
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.failed)
                begin
                    // failed stream: swallow bytes until the last one
                    cmd.restart = sts.last;
                    state_next  = ST_IDLE;
                end
                else if (!sts.prefix_valid)
                begin
                    cmd.load_first = 1'b1;
                    state_next     = sts.last ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_done)
                begin
                    if (sts.search_hit)
                    begin
                        cmd.load_hit = 1'b1;
                        state_next   = sts.last ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MISS;
                    end
                end
            end
            ST_MISS:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_end = !(sts.emit_ok && sts.last);
                    if (sts.emit_ok)
                    begin
                        cmd.add_entry = 1'b1;
                        state_next    = sts.last ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        cmd.restart = sts.last;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_end = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/lzwenc16_dp.sv */
`timescale 1ns / 1ps

module lzwenc16_dp #(
    parameter int DICT_ENTRIES = lzwenc16_pkg::DICT_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lzwenc16_pkg::in_word_t              in_word,
    input  logic                                cfg_valid,
    input  logic [lzwenc16_pkg::CAP_W-1:0]      cfg_data,
    input  lzwenc16_pkg::ctrl_cmd_t             cmd,
    output lzwenc16_pkg::ctrl_sts_t             sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lzwenc16_pkg::out_word_t             out_word
);

    import lzwenc16_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int NW = AW + 1;
    localparam logic [NW-1:0] FIRST_NFC  = NW'(FIRST_CODE);
    localparam logic [NW-1:0] DICT_LIMIT = NW'(DICT_ENTRIES);

    // Captured byte and stream state
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [NW-1:0]     nfc_reg;
    logic [NW-1:0]     nfc_next;
    logic [CODE_W-1:0] pending_reg;
    logic [CODE_W-1:0] pending_next;
    logic              pvalid_reg;
    logic              pvalid_next;
    logic [CAP_W-1:0]  sent_reg;
    logic [CAP_W-1:0]  sent_next;
    logic              failed_reg;
    logic              failed_next;

    // Search pipeline
    logic              active_reg;
    logic              active_next;
    logic [NW-1:0]     cnt_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     cmp_addr_reg;
    logic              issue;
    logic              match;
    logic              done;
    logic [ENTRY_W-1:0] rd_data;

    // Output register
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    logic              emit_ok;
    logic              room;

    logic              wr_en;

    assign emit_ok = (sent_reg < cap_reg);
    assign room    = (nfc_reg < DICT_LIMIT);
    assign wr_en   = cmd.add_entry && room;

    lzwenc16_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (nfc_reg[AW-1:0]),
        .wr_data ({pending_reg, byte_reg}),
        .rd_en   (issue),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Linear scan: one read issued per cycle, compared in the next cycle
    assign issue = active_reg && (cnt_reg < nfc_reg);
    assign match = cmp_valid_reg && (rd_data == {pending_reg, byte_reg});
    assign done  = active_reg && (match || (!issue && !cmp_valid_reg));

    always_comb
    begin
        active_next = active_reg;
        if (cmd.search_start)
        begin
            active_next = 1'b1;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search_start)
        begin
            cnt_reg <= FIRST_NFC;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        cmp_addr_reg <= cnt_reg[AW-1:0];
    end

    // Stream state update
    always_comb
    begin
        nfc_next     = nfc_reg;
        pending_next = pending_reg;
        pvalid_next  = pvalid_reg;
        sent_next    = sent_reg;
        failed_next  = failed_reg;
        if (cmd.load_first)
        begin
            pending_next = CODE_W'(byte_reg);
            pvalid_next  = 1'b1;
        end
        if (cmd.load_hit)
        begin
            pending_next = CODE_W'(cmp_addr_reg);
        end
        if (cmd.emit)
        begin
            if (emit_ok)
            begin
                sent_next = sent_reg + 1'b1;
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
        if (cmd.add_entry)
        begin
            if (room)
            begin
                nfc_next = nfc_reg + 1'b1;
            end
            pending_next = CODE_W'(byte_reg);
        end
        if (cmd.restart)
        begin
            nfc_next     = FIRST_NFC;
            pending_next = '0;
            pvalid_next  = 1'b0;
            sent_next    = '0;
            failed_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            nfc_reg       <= FIRST_NFC;
            pending_reg   <= '0;
            pvalid_reg    <= 1'b0;
            sent_reg      <= '0;
            failed_reg    <= 1'b0;
            active_reg    <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            nfc_reg       <= nfc_next;
            pending_reg   <= pending_next;
            pvalid_reg    <= pvalid_next;
            sent_reg      <= sent_next;
            failed_reg    <= failed_next;
            active_reg    <= active_next;
            cmp_valid_reg <= issue && !done;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Byte capture and output word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_word.byte_in;
            last_reg <= in_word.last_byte;
        end
        if (cmd.emit)
        begin
            out_word_reg.code_out   <= emit_ok ? pending_reg : '0;
            out_word_reg.overflow   <= !emit_ok;
            out_word_reg.end_of_run <= cmd.emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Status back to the controller
    always_comb
    begin
        sts              = '0;
        sts.failed       = failed_reg;
        sts.prefix_valid = pvalid_reg;
        sts.last         = last_reg;
        sts.search_done  = done;
        sts.search_hit   = match;
        sts.slot_free    = !out_valid_reg || out_ready;
        sts.emit_ok      = emit_ok;
    end

endmodule

/* bench/lzw_code_checker.sv */
`timescale 1ns / 1ps

module lzw_code_checker #(
    parameter int DICT_ENTRIES = lzwenc16_pkg::DICT_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  lzwenc16_pkg::in_word_t         in_word,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  lzwenc16_pkg::out_word_t        out_word,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lzwenc16_pkg::CAP_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    import lzwenc16_pkg::*;

    // Dictionary and stream state of the encoder
    logic [CODE_W-1:0] tbl_prefix [DICT_ENTRIES];
    logic [BYTE_W-1:0] tbl_byte [DICT_ENTRIES];
    logic [16:0]       free_code;
    logic [CODE_W-1:0] cur_prefix;
    logic              have_prefix;
    logic [CAP_W-1:0]  sent_count;
    logic              failed;
    logic [CAP_W-1:0]  capacity;

    // Codes still owed by the block, oldest first
    out_word_t code_queue[$];
    out_word_t item_codes[2];
    int        item_count;

    // Back to an empty dictionary; capacity is kept
    task automatic restart_stream();
        free_code   = 17'(FIRST_CODE);
        cur_prefix  = '0;
        have_prefix = 1'b0;
        sent_count  = '0;
        failed      = 1'b0;
    endtask

    // Emit the pending prefix, or the overflow word once capacity is used up
    task automatic emit_prefix(output bit ok);
        out_word_t w;
        w = '0;
        if (sent_count < capacity) begin
            w.code_out = cur_prefix;
            sent_count = sent_count + 1'b1;
            ok = 1'b1;
        end
        else begin
            w.overflow = 1'b1;
            failed = 1'b1;
            ok = 1'b0;
        end
        item_codes[item_count] = w;
        item_count++;
    endtask

    // Work out the codes one source byte produces
    task automatic encode_byte(input in_word_t w);
        int j;
        int limit;
        int k;
        bit hit;
        bit ok;
        item_count = 0;
        hit = 1'b0;
        ok = 1'b1;
        // failed stream swallows bytes until its last one
        if (failed) begin
            if (w.last_byte)
                restart_stream();
            return;
        end
        if (!have_prefix) begin
            cur_prefix = CODE_W'(w.byte_in);
            have_prefix = 1'b1;
        end
        else begin
            limit = (free_code > DICT_ENTRIES) ? DICT_ENTRIES : int'(free_code);
            j = FIRST_CODE;
            while (j < limit && !hit) begin
                if (tbl_prefix[j] == cur_prefix && tbl_byte[j] == w.byte_in)
                    hit = 1'b1;
                else
                    j++;
            end
            if (hit)
                cur_prefix = CODE_W'(j);
            else begin
                emit_prefix(ok);
                if (ok) begin
                    // no new entries once the dictionary is full
                    if (free_code < DICT_ENTRIES) begin
                        tbl_prefix[free_code] = cur_prefix;
                        tbl_byte[free_code] = w.byte_in;
                        free_code = free_code + 1'b1;
                    end
                    cur_prefix = CODE_W'(w.byte_in);
                end
            end
        end
        if (w.last_byte) begin
            if (ok)
                emit_prefix(ok);
            restart_stream();
        end
        for (k = 0; k < item_count; k++) begin
            if (k == item_count - 1)
                item_codes[k].end_of_run = 1'b1;
            code_queue.push_back(item_codes[k]);
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge clk) begin : watch
        out_word_t want;
        if (!rst_n) begin
            code_queue.delete();
            capacity = CAP_RESET;
            restart_stream();
            mismatches = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (out_valid && out_ready) begin
                if (code_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected word: code %h overflow %b end %b",
                                 out_word.code_out, out_word.overflow,
                                 out_word.end_of_run);
                    mismatches++;
                end
                else begin
                    want = code_queue.pop_front();
                    if (want.code_out !== out_word.code_out
                        || want.overflow !== out_word.overflow
                        || want.end_of_run !== out_word.end_of_run) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected code %h overflow %b end %b,",
                                      " got code %h overflow %b end %b"},
                                     want.code_out, want.overflow, want.end_of_run,
                                     out_word.code_out, out_word.overflow,
                                     out_word.end_of_run);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                encode_byte(in_word);
        end
        outstanding = code_queue.size();
    end

endmodule

/* bench/lzw_encoder_16bit_codes_top_tb.sv */
`timescale 1ns / 1ps

module lzw_encoder_16bit_codes_top_tb;
    import lzwenc16_pkg::*;

    localparam int DICT_SIZE    = 512;
    // worst search over a full dictionary plus some margin
    localparam int IDLE_WAIT    = DICT_SIZE - FIRST_CODE + 64;
    localparam int RUN_LIMIT_NS = 5_000_000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_word_t         in_word;
    logic             out_valid;
    logic             out_ready;
    out_word_t        out_word;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;
    int               mismatches;
    int               outstanding;
    bit               calm;

    lzw_encoder_16bit_codes_top #(
        .DICT_ENTRIES(DICT_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    lzw_code_checker #(
        .DICT_ENTRIES(DICT_SIZE)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop for a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Mostly short gaps, now and then a long one; no gaps while calm
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte and hold it until taken
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last_flag);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= '{byte_in: b, last_byte: last_flag};
        do @(posedge clk); while (!in_ready);
    endtask

    // Let every owed word arrive, then give the block time to go idle
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls on out_ready
    initial begin : receiver
        int stall;
        int run;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                @(negedge clk) out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            run = $urandom_range(1, 16);
            @(negedge clk) out_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] fill_bytes [24];
        logic [CAP_W-1:0]  cap;
        int                i;
        int                s;
        int                n;
        int                len;
        int                mode;
        int                base;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // single-byte streams at both byte extremes
        write_cap(CAP_RESET);
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        // alternating pair: entries get built and then hit
        for (i = 0; i < 7; i++)
            put_byte((i % 2) ? 8'h42 : 8'h41, i == 6);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1);
        calm = 1'b0;

        // zero capacity: first code overflows, rest of stream ignored
        write_cap('0);
        put_byte(8'h55, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b0);
        put_byte(8'h03, 1'b1);

        // capacity one: overflow mid-stream, then on the final flush
        write_cap(24'd1);
        put_byte(8'h10, 1'b0);
        put_byte(8'h20, 1'b0);
        put_byte(8'h30, 1'b0);
        put_byte(8'h40, 1'b1);
        put_byte(8'h80, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b1);

        // one longer random stream, then replay its start to hit old entries
        write_cap(CAP_RESET);
        for (i = 0; i < 24; i++) begin
            fill_bytes[i] = BYTE_W'($urandom_range(0, 255));
            put_byte(fill_bytes[i], 1'b0);
        end
        for (i = 0; i < 8; i++)
            put_byte(fill_bytes[i], i == 7);

        // random streams under several capacities
        for (s = 0; s < 6; s++) begin
            case (s)
                0:       cap = CAP_RESET;
                1:       cap = CAP_W'($urandom_range(0, 3));
                2:       cap = CAP_W'($urandom);
                3:       cap = CAP_W'($urandom_range(4, 12));
                4:       cap = '0;
                default: cap = CAP_W'($urandom_range(13, 40));
            endcase
            write_cap(cap);
            calm = (s == 2);
            n = 0;
            while (n < 5) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                   : $urandom_range(1, 10);
                mode = $urandom_range(0, 3);
                base = $urandom_range(0, 255);
                for (i = 0; i < len; i++)
                    put_byte((mode == 0) ? BYTE_W'($urandom_range(0, 255))
                                         : BYTE_W'(base + $urandom_range(0, mode)),
                             i == len - 1);
                n += len;
                // sender holds off until everything owed has come out
                if ((s == 0 && n == len) || $urandom_range(0, 4) == 0)
                    drain();
            end
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
